// ===== rtl/ptir_pkg.sv =====
// Shared constants, types and helper functions for the primitive index remap block.
// Used by every module under rtl/; depends on nothing else.
package ptir_pkg;

  localparam int INDEX_BITS     = 24;
  localparam int CORNER_BITS    = 3;
  localparam int TOPO_BITS      = 4;
  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = INDEX_BITS;
  localparam int S_TDATA_BITS   = ((INDEX_BITS + 7) / 8) * 8;
  localparam int M_FIELD_BITS   = 2 * INDEX_BITS + CORNER_BITS;
  localparam int M_TDATA_BITS   = ((M_FIELD_BITS + 7) / 8) * 8;
  localparam int QUEUE_DEPTH    = 2;

  // Divide by three as a multiply by a rounded-up reciprocal and a shift.
  localparam int DIV3_SHIFT = INDEX_BITS + 2;
  localparam logic [INDEX_BITS:0] DIV3_MUL =
    (INDEX_BITS + 1)'(((64'd1 << DIV3_SHIFT) + 64'd2) / 64'd3);

  localparam logic [CFG_INDEX_BITS-1:0] REG_TOPOLOGY   = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_VERT_TOTAL = CFG_INDEX_BITS'(1);

  localparam logic [TOPO_BITS-1:0] TOPO_POINTS         = 4'd0;
  localparam logic [TOPO_BITS-1:0] TOPO_LINES          = 4'd1;
  localparam logic [TOPO_BITS-1:0] TOPO_LINE_LOOP      = 4'd2;
  localparam logic [TOPO_BITS-1:0] TOPO_LINE_STRIP     = 4'd3;
  localparam logic [TOPO_BITS-1:0] TOPO_TRIANGLES      = 4'd4;
  localparam logic [TOPO_BITS-1:0] TOPO_TRI_STRIP      = 4'd5;
  localparam logic [TOPO_BITS-1:0] TOPO_TRI_FAN        = 4'd6;
  localparam logic [TOPO_BITS-1:0] TOPO_QUADS          = 4'd7;
  localparam logic [TOPO_BITS-1:0] TOPO_QUAD_STRIP     = 4'd8;
  localparam logic [TOPO_BITS-1:0] TOPO_POLYGON        = 4'd9;
  localparam logic [TOPO_BITS-1:0] TOPO_LINES_ADJ      = 4'd10;
  localparam logic [TOPO_BITS-1:0] TOPO_LINE_STRIP_ADJ = 4'd11;
  localparam logic [TOPO_BITS-1:0] TOPO_TRIS_ADJ       = 4'd12;
  localparam logic [TOPO_BITS-1:0] TOPO_TRI_STRIP_ADJ  = 4'd13;
  localparam logic [TOPO_BITS-1:0] TOPO_PATCHES        = 4'd14;

  // Per-corner offset patterns added to an item's base vertex.
  typedef enum logic [2:0] {
    PAT_LINEAR,
    PAT_SWAP01,
    PAT_QUAD_ODD,
    PAT_QSTRIP_ODD,
    PAT_TSA_ODD
  } pat_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0]  base;
    logic [INDEX_BITS-1:0]  count;
    logic [CORNER_BITS-1:0] last_k;
    pat_t                   pat;
    logic                   zero_first;
    logic                   wrap_second;
    logic                   in_range;
  } item_t;

  function automatic logic [CORNER_BITS-1:0] last_corner(input logic [TOPO_BITS-1:0] topo);
    logic [CORNER_BITS-1:0] r;
    case (topo)
      TOPO_LINES, TOPO_LINE_LOOP, TOPO_LINE_STRIP: r = 3'd1;
      TOPO_TRIANGLES, TOPO_TRI_STRIP, TOPO_TRI_FAN, TOPO_QUADS, TOPO_QUAD_STRIP,
      TOPO_POLYGON: r = 3'd2;
      TOPO_LINES_ADJ, TOPO_LINE_STRIP_ADJ: r = 3'd3;
      TOPO_TRIS_ADJ, TOPO_TRI_STRIP_ADJ: r = 3'd5;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [CORNER_BITS-1:0] corner_offset(input pat_t pat,
                                                            input logic [CORNER_BITS-1:0] k);
    logic [CORNER_BITS-1:0] r;
    case (pat)
      PAT_SWAP01: begin
        case (k)
          3'd0:    r = 3'd1;
          3'd1:    r = 3'd0;
          default: r = k;
        endcase
      end
      PAT_QUAD_ODD:   r = (k == 3'd0) ? 3'd0 : k + 3'd1;
      PAT_QSTRIP_ODD: r = k + 3'd1;
      PAT_TSA_ODD: begin
        case (k)
          3'd0:    r = 3'd2;
          3'd1:    r = 3'd3;
          3'd2:    r = 3'd0;
          3'd3:    r = 3'd1;
          default: r = k;
        endcase
      end
      default: r = k;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/ptir_front.sv =====
// Front end: configuration registers, primitive count, input stage and classification.
// Depends on ptir_pkg; feeds ptir_queue.
module ptir_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ptir_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [ptir_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [ptir_pkg::S_TDATA_BITS-1:0]   s_tdata,
  input  logic                                q_full,
  output logic                                q_push,
  output ptir_pkg::item_t                     q_item
);

  localparam int IB = ptir_pkg::INDEX_BITS;

  logic [ptir_pkg::TOPO_BITS-1:0] topology;
  logic [IB-1:0]                  vert_total;
  logic [IB-1:0]                  prim_count;
  logic [IB-1:0]                  prim_count_next;
  logic [2*IB:0]                  div3_prod;
  logic [IB-1:0]                  div3;
  logic [IB-1:0]                  vm2;
  logic                           fv;
  logic [IB-1:0]                  p;
  logic [IB-1:0]                  q2;
  logic [IB-1:0]                  q4;

  assign cfg_ready = 1'b1;

  // The count is registered from the configuration registers and follows them in the next cycle.
  always_comb begin
    div3_prod = (2*IB+1)'(vert_total) * (2*IB+1)'(ptir_pkg::DIV3_MUL);
    div3      = IB'(div3_prod >> ptir_pkg::DIV3_SHIFT);
    vm2       = vert_total - IB'(2);
    case (topology)
      ptir_pkg::TOPO_LINES:      prim_count_next = vert_total >> 1;
      ptir_pkg::TOPO_LINE_LOOP:  prim_count_next = (vert_total > IB'(1)) ? vert_total : '0;
      ptir_pkg::TOPO_LINE_STRIP:
        prim_count_next = (vert_total > IB'(1)) ? vert_total - IB'(1) : '0;
      ptir_pkg::TOPO_TRIANGLES:  prim_count_next = div3;
      ptir_pkg::TOPO_TRI_STRIP, ptir_pkg::TOPO_TRI_FAN, ptir_pkg::TOPO_POLYGON:
        prim_count_next = (vert_total > IB'(2)) ? vm2 : '0;
      ptir_pkg::TOPO_QUADS:      prim_count_next = (vert_total >> 2) << 1;
      ptir_pkg::TOPO_QUAD_STRIP:
        prim_count_next = (vert_total > IB'(3)) ? ((vm2 >> 1) << 1) : '0;
      ptir_pkg::TOPO_LINES_ADJ:  prim_count_next = vert_total >> 2;
      ptir_pkg::TOPO_LINE_STRIP_ADJ:
        prim_count_next = (vert_total > IB'(3)) ? vert_total - IB'(3) : '0;
      ptir_pkg::TOPO_TRIS_ADJ:   prim_count_next = div3 >> 1;
      ptir_pkg::TOPO_TRI_STRIP_ADJ:
        prim_count_next = (vert_total > IB'(2)) ? (vm2 >> 1) : '0;
      default:                   prim_count_next = vert_total;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      topology   <= '0;
      vert_total <= '0;
      prim_count <= '0;
    end else begin
      prim_count <= prim_count_next;
      if (cfg_valid) begin
        if (cfg_index == ptir_pkg::REG_TOPOLOGY) begin
          topology <= cfg_data[ptir_pkg::TOPO_BITS-1:0];
        end else if (cfg_index == ptir_pkg::REG_VERT_TOTAL) begin
          vert_total <= cfg_data[IB-1:0];
        end
      end
    end
  end

  // Input stage: one beat held until the queue takes it.
  assign s_tready = !fv || !q_full;
  assign q_push   = fv && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      fv <= 1'b1;
    end else if (q_push) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      p <= s_tdata[IB-1:0];
    end
  end

  assign q2 = {p[IB-1:1], 1'b0};
  assign q4 = {p[IB-2:1], 2'b00};

  always_comb begin
    q_item             = '0;
    q_item.count       = prim_count;
    q_item.in_range    = p < prim_count;
    q_item.pat         = ptir_pkg::PAT_LINEAR;
    q_item.base        = p;
    if (q_item.in_range) begin
      q_item.last_k = ptir_pkg::last_corner(topology);
      case (topology)
        ptir_pkg::TOPO_LINES:     q_item.base = p << 1;
        ptir_pkg::TOPO_LINE_LOOP: q_item.wrap_second = (p == vert_total - IB'(1));
        ptir_pkg::TOPO_TRIANGLES: q_item.base = p + (p << 1);
        ptir_pkg::TOPO_TRI_STRIP:
          q_item.pat = p[0] ? ptir_pkg::PAT_SWAP01 : ptir_pkg::PAT_LINEAR;
        ptir_pkg::TOPO_TRI_FAN, ptir_pkg::TOPO_POLYGON: q_item.zero_first = 1'b1;
        ptir_pkg::TOPO_QUADS: begin
          q_item.base = q4;
          q_item.pat  = p[0] ? ptir_pkg::PAT_QUAD_ODD : ptir_pkg::PAT_LINEAR;
        end
        ptir_pkg::TOPO_QUAD_STRIP: begin
          // The first quad splits from vertex 0; later quads pivot on 2q+1.
          if (p[IB-1:1] == '0) begin
            q_item.base = '0;
            q_item.pat  = p[0] ? ptir_pkg::PAT_QUAD_ODD : ptir_pkg::PAT_LINEAR;
          end else begin
            q_item.base = q2;
            q_item.pat  = p[0] ? ptir_pkg::PAT_QSTRIP_ODD : ptir_pkg::PAT_SWAP01;
          end
        end
        ptir_pkg::TOPO_LINES_ADJ: q_item.base = p << 2;
        ptir_pkg::TOPO_TRIS_ADJ:  q_item.base = (p << 2) + (p << 1);
        ptir_pkg::TOPO_TRI_STRIP_ADJ: begin
          q_item.base = p << 1;
          q_item.pat  = p[0] ? ptir_pkg::PAT_TSA_ODD : ptir_pkg::PAT_LINEAR;
        end
        default: q_item.base = p;
      endcase
    end else begin
      q_item.base   = '0;
      q_item.last_k = '0;
    end
  end

endmodule

// ===== rtl/ptir_queue.sv =====
// Two-entry queue of classified items between the front and back ends.
// Depends on ptir_pkg for the item type and depth.
module ptir_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ptir_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output ptir_pkg::item_t head
);

  localparam int PTR_BITS = $clog2(ptir_pkg::QUEUE_DEPTH);
  localparam int CNT_BITS = $clog2(ptir_pkg::QUEUE_DEPTH + 1);

  ptir_pkg::item_t     mem [ptir_pkg::QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] fill;

  assign full       = (fill == CNT_BITS'(ptir_pkg::QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(ptir_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(ptir_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== rtl/ptir_back.sv =====
// Back end: walks the corners of the queue head and drives the registered result stream.
// Depends on ptir_pkg; reads from ptir_queue.
module ptir_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              head_valid,
  input  ptir_pkg::item_t                   head,
  output logic                              pop,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // m_tdata fields from bit 0: vertex_index, corner, primitive_count, zero fill
  output logic [ptir_pkg::M_TDATA_BITS-1:0] m_tdata,
  output logic                              m_tlast,
  // m_tuser fields from bit 0: in_range
  output logic                              m_tuser
);

  localparam int IB = ptir_pkg::INDEX_BITS;

  logic [ptir_pkg::CORNER_BITS-1:0] k;
  logic                             emit;
  logic                             is_last;
  logic [IB-1:0]                    vtx;
  logic [ptir_pkg::CORNER_BITS-1:0] off;

  assign emit    = head_valid && (!m_tvalid || m_tready);
  assign is_last = (k == head.last_k);
  assign pop     = emit && is_last;

  always_comb begin
    off = ptir_pkg::corner_offset(head.pat, k);
    if (head.zero_first && (k == '0)) begin
      vtx = '0;
    end else if (head.wrap_second && (k == ptir_pkg::CORNER_BITS'(1))) begin
      vtx = '0;
    end else begin
      vtx = head.base + IB'(off);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k        <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (emit) begin
        m_tvalid <= 1'b1;
        k        <= is_last ? '0 : k + 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= ptir_pkg::M_TDATA_BITS'({head.count, k, vtx});
      m_tlast <= is_last;
      m_tuser <= head.in_range;
    end
  end

endmodule

// ===== rtl/primitive_topology_index_remap.sv =====
// Top level of the primitive index remap block: front end, item queue, back end.
// Depends on ptir_pkg, ptir_front, ptir_queue and ptir_back.
//
// Usage: write topology (index 0) and the vertex count (index 1) on the cfg channel,
// which is always ready, while the block is idle. Each s_tdata beat names one primitive;
// the m channel returns that primitive's corner vertices as a run closed by m_tlast.
// A primitive at or past the primitive count returns one beat with vertex 0 and
// m_tuser clear. Every beat carries the primitive count.
// A taken input beat passes through the input stage, a queue entry and the output register.
// Throughput: one output beat per cycle while m_tready is high; an item gives 1 to 6 beats,
// set by its corner count; the front end takes one item per cycle while the two-entry queue
// has room.
// The primitive count is recomputed in the cycle after a configuration write.
// Reset clears both configuration registers, the queue and the output stage.
// When m_tready is low the output beat holds, the queue fills, and s_tready drops
// once the input stage and both queue entries are occupied.
module primitive_topology_index_remap (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ptir_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [ptir_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // s_tdata fields from bit 0: primitive_index
  input  logic [ptir_pkg::S_TDATA_BITS-1:0]   s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // m_tdata fields from bit 0: vertex_index, corner, primitive_count, zero fill
  output logic [ptir_pkg::M_TDATA_BITS-1:0]   m_tdata,
  output logic                                m_tlast,
  // m_tuser fields from bit 0: in_range
  output logic                                m_tuser
);

  localparam int IB = ptir_pkg::INDEX_BITS;

  logic            q_full;
  logic            q_push;
  logic            q_pop;
  logic            q_head_valid;
  ptir_pkg::item_t q_item;
  ptir_pkg::item_t q_head;

  ptir_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_item)
  );

  ptir_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (q_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  ptir_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser)
  );

  // An out-of-range primitive is a single beat carrying vertex 0.
  a_out_of_range_single : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tlast && (m_tdata[IB-1:0] == '0)))
    else $error("out-of-range result is not a single zero beat");

  // Within a run the next corner follows in the very next cycle.
  a_corner_advance : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=>
      (m_tvalid && (m_tdata[IB+ptir_pkg::CORNER_BITS-1:IB] ==
                    $past(m_tdata[IB+ptir_pkg::CORNER_BITS-1:IB]) + 3'd1)))
    else $error("corner sequence broken inside a run");

  // The queue is never popped while empty.
  a_pop_nonempty : assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_head_valid)
    else $error("queue popped while empty");

endmodule

// ===== bench/ptir_corner_checker.sv =====
// Corner-run checker for the primitive index remap block: tracks the configuration
// writes, predicts each primitive's corner beats and compares them with the m channel.
// Depends on ptir_pkg for widths, topology codes and register indexes.
`timescale 1ns / 1ps

module ptir_corner_checker
  import ptir_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      s_tvalid,
  input  logic                      s_tready,
  // s_tdata fields from bit 0: primitive_index
  input  logic [S_TDATA_BITS-1:0]   s_tdata,
  input  logic                      m_tvalid,
  input  logic                      m_tready,
  // m_tdata fields from bit 0: vertex_index, corner, primitive_count, zero fill
  input  logic [M_TDATA_BITS-1:0]   m_tdata,
  input  logic                      m_tlast,
  // m_tuser fields from bit 0: in_range
  input  logic                      m_tuser,
  output logic [INDEX_BITS-1:0]     prim_total,
  output int                        mismatches,
  output int                        pending,
  output int                        beats_seen
);

  typedef struct packed {
    logic [INDEX_BITS-1:0]  vertex;
    logic [CORNER_BITS-1:0] corner;
    logic                   closes_run;
    logic                   in_range;
    logic [INDEX_BITS-1:0]  count;
  } corner_beat_t;

  logic [TOPO_BITS-1:0]  topo_now  = '0;
  logic [INDEX_BITS-1:0] verts_now = '0;
  corner_beat_t          expected_corners[$];

  function automatic logic [INDEX_BITS-1:0] prims_for(input logic [TOPO_BITS-1:0] topo,
                                                      input logic [INDEX_BITS-1:0] verts);
    int unsigned v;
    int unsigned r;
    v = 32'(verts);
    case (topo)
      TOPO_LINES:                               r = v / 2;
      TOPO_LINE_LOOP:                           r = (v > 1) ? v : 0;
      TOPO_LINE_STRIP:                          r = (v > 1) ? v - 1 : 0;
      TOPO_TRIANGLES:                           r = v / 3;
      TOPO_TRI_STRIP, TOPO_TRI_FAN, TOPO_POLYGON: r = (v > 2) ? v - 2 : 0;
      TOPO_QUADS:                               r = (v / 4) * 2;
      TOPO_QUAD_STRIP:                          r = (v > 3) ? ((v - 2) / 2) * 2 : 0;
      TOPO_LINES_ADJ:                           r = v / 4;
      TOPO_LINE_STRIP_ADJ:                      r = (v > 3) ? v - 3 : 0;
      TOPO_TRIS_ADJ:                            r = v / 6;
      TOPO_TRI_STRIP_ADJ:                       r = (v > 2) ? (v - 2) / 2 : 0;
      default:                                  r = v;
    endcase
    return r[INDEX_BITS-1:0];
  endfunction

  function automatic int unsigned corner_span(input logic [TOPO_BITS-1:0] topo);
    case (topo)
      TOPO_LINES, TOPO_LINE_LOOP, TOPO_LINE_STRIP: return 2;
      TOPO_TRIANGLES, TOPO_TRI_STRIP, TOPO_TRI_FAN, TOPO_QUADS, TOPO_QUAD_STRIP,
      TOPO_POLYGON: return 3;
      TOPO_LINES_ADJ, TOPO_LINE_STRIP_ADJ: return 4;
      TOPO_TRIS_ADJ, TOPO_TRI_STRIP_ADJ: return 6;
      default: return 1;
    endcase
  endfunction

  function automatic logic [INDEX_BITS-1:0] source_vertex(input logic [TOPO_BITS-1:0] topo,
                                                          input logic [INDEX_BITS-1:0] prim,
                                                          input logic [INDEX_BITS-1:0] verts,
                                                          input int unsigned k);
    int unsigned p;
    int unsigned q;
    int unsigned odd;
    int unsigned r;
    p   = 32'(prim);
    q   = p >> 1;
    odd = 32'(prim[0]);
    case (topo)
      TOPO_LINES:     r = 2 * p + k;
      // The loop's final segment closes back to the first vertex.
      TOPO_LINE_LOOP: r = (k == 0) ? p : ((p + 1 < 32'(verts)) ? p + 1 : 0);
      TOPO_LINE_STRIP, TOPO_LINE_STRIP_ADJ: r = p + k;
      TOPO_TRIANGLES: r = 3 * p + k;
      TOPO_TRI_STRIP: begin
        if (odd != 0) r = (k == 0) ? p + 1 : ((k == 1) ? p : p + 2);
        else r = p + k;
      end
      TOPO_TRI_FAN, TOPO_POLYGON: r = (k == 0) ? 0 : p + k;
      TOPO_QUADS:     r = (k == 0) ? 4 * q : 4 * q + k + odd;
      TOPO_QUAD_STRIP: begin
        // The first quad is split differently from every later one.
        if (q == 0) r = (k == 0) ? 0 : k + odd;
        else if (odd == 0) r = (k == 0) ? 2 * q + 1 : ((k == 1) ? 2 * q : 2 * q + 2);
        else r = 2 * q + 1 + k;
      end
      TOPO_LINES_ADJ: r = 4 * p + k;
      TOPO_TRIS_ADJ:  r = 6 * p + k;
      TOPO_TRI_STRIP_ADJ: begin
        r = 2 * p + k;
        if (odd != 0) begin
          case (k)
            0: r = 2 * p + 2;
            1: r = 2 * p + 3;
            2: r = 2 * p;
            3: r = 2 * p + 1;
            default: ;
          endcase
        end
      end
      default: r = p;
    endcase
    return r[INDEX_BITS-1:0];
  endfunction

  function automatic void queue_primitive(input logic [INDEX_BITS-1:0] prim);
    logic [INDEX_BITS-1:0] total;
    int unsigned           n;
    corner_beat_t          beat;
    total = prims_for(topo_now, verts_now);
    if (prim >= total) begin
      beat = '{vertex: '0, corner: '0, closes_run: 1'b1, in_range: 1'b0, count: total};
      expected_corners.insert(expected_corners.size(), beat);
    end else begin
      n = corner_span(topo_now);
      for (int unsigned k = 0; k < n; k++) begin
        beat.vertex     = source_vertex(topo_now, prim, verts_now, k);
        beat.corner     = CORNER_BITS'(k);
        beat.closes_run = (k + 1 == n);
        beat.in_range   = 1'b1;
        beat.count      = total;
        expected_corners.insert(expected_corners.size(), beat);
      end
    end
  endfunction

  assign prim_total = prims_for(topo_now, verts_now);

  always @(posedge clk) begin
    corner_beat_t want;
    corner_beat_t got;
    if (rst) begin
      expected_corners.delete();
      topo_now   = '0;
      verts_now  = '0;
      mismatches = 0;
      beats_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TOPOLOGY:   topo_now  = cfg_data[TOPO_BITS-1:0];
          REG_VERT_TOTAL: verts_now = cfg_data[INDEX_BITS-1:0];
          default: ;
        endcase
      end
      // Results are checked before new predictions go in: the block cannot answer
      // a primitive in the same cycle it takes it.
      if (m_tvalid && m_tready) begin
        got.vertex     = m_tdata[INDEX_BITS-1:0];
        got.corner     = m_tdata[INDEX_BITS +: CORNER_BITS];
        got.closes_run = m_tlast;
        got.in_range   = m_tuser;
        got.count      = m_tdata[INDEX_BITS+CORNER_BITS +: INDEX_BITS];
        beats_seen++;
        if (expected_corners.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat %0d arrived with nothing expected: %s %0d %s %0d %s %0b %s %0b %s %0d",
                     beats_seen, "vertex", got.vertex, "corner", got.corner,
                     "last", got.closes_run, "in_range", got.in_range,
                     "count", got.count);
        end else begin
          want = expected_corners.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("beat %0d differs: expected vertex %0d corner %0d last %0b",
                       beats_seen, want.vertex, want.corner, want.closes_run);
              $display("  expected in_range %0b count %0d",
                       want.in_range, want.count);
              $display("  got vertex %0d corner %0d last %0b in_range %0b count %0d",
                       got.vertex, got.corner, got.closes_run, got.in_range, got.count);
            end
          end
        end
      end
      if (s_tvalid && s_tready) queue_primitive(s_tdata[INDEX_BITS-1:0]);
    end
    pending = expected_corners.size();
  end

endmodule

// ===== bench/primitive_topology_index_remap_tb.sv =====
// Top of the primitive index remap bench: clock, reset, configuration writes,
// primitive requests and a randomly stalling result sink, plus the final verdict.
// Depends on ptir_pkg, the block itself and ptir_corner_checker.
`timescale 1ns / 1ps

module primitive_topology_index_remap_tb;
  import ptir_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam logic [INDEX_BITS-1:0] INDEX_MAX = '1;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      cfg_valid = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;
  logic                      s_tvalid  = 1'b0;
  logic [S_TDATA_BITS-1:0]   s_tdata   = '0;
  logic                      m_tready  = 1'b0;
  logic                      cfg_ready;
  logic                      s_tready;
  logic                      m_tvalid;
  logic [M_TDATA_BITS-1:0]   m_tdata;
  logic                      m_tlast;
  logic                      m_tuser;

  logic [INDEX_BITS-1:0] prim_total;
  int                    mismatches;
  int                    pending;
  int                    beats_seen;
  logic                  no_idle       = 1'b0;
  int                    quiet_cycles  = 0;
  int                    prims_sent    = 0;
  int                    settings_used = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  primitive_topology_index_remap u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  ptir_corner_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser),
    .prim_total (prim_total),
    .mismatches (mismatches),
    .pending    (pending),
    .beats_seen (beats_seen)
  );

  // The run ends early if no beat moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
      $display("primitive_topology_index_remap: mismatch");
      $finish;
    end
  end

  // Result sink: a random stall before each beat, none while no_idle is set.
  initial begin
    int stall;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 7);
      @(negedge clk);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
    end
  end

  task automatic wait_drained();
    while (pending != 0) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Registers change only with the block idle, so the input goes quiet and every
  // outstanding corner beat is collected first.
  task automatic configure(input logic [TOPO_BITS-1:0] topo,
                           input logic [INDEX_BITS-1:0] verts);
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait_drained();
    cfg_write(REG_TOPOLOGY, CFG_DATA_BITS'(topo));
    cfg_write(REG_VERT_TOTAL, CFG_DATA_BITS'(verts));
    settings_used++;
  endtask

  task automatic send_prim(input logic [INDEX_BITS-1:0] prim);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= S_TDATA_BITS'(prim);
    do @(posedge clk); while (s_tready !== 1'b1);
    prims_sent++;
  endtask

  function automatic logic [INDEX_BITS-1:0] pick_verts();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return INDEX_BITS'($urandom_range(0, 40));
    if (sel < 6) return INDEX_BITS'($urandom_range(0, 1000));
    if (sel < 9) return INDEX_BITS'($urandom);
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return INDEX_BITS'(1);
      2:       return INDEX_BITS'(2);
      3:       return INDEX_BITS'(3);
      default: return INDEX_MAX;
    endcase
  endfunction

  // Mostly primitives that exist, some just past the end, some anywhere.
  function automatic logic [INDEX_BITS-1:0] pick_prim();
    int sel;
    sel = $urandom_range(0, 9);
    if (prim_total != 0 && sel < 8)
      return INDEX_BITS'($urandom_range(0, int'(prim_total) - 1));
    if (sel == 8) return prim_total + INDEX_BITS'($urandom_range(0, 1));
    return INDEX_BITS'($urandom);
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // With the reset configuration there are no primitives at all.
    send_prim('0);
    send_prim(INDEX_MAX);

    // The final primitive of every topology, plus both parities where winding
    // or the quad split depends on it.
    for (int t = 0; t < 16; t++) begin
      configure(TOPO_BITS'(t), INDEX_BITS'(13));
      send_prim(prim_total - INDEX_BITS'(1));
      case (TOPO_BITS'(t))
        TOPO_TRI_STRIP, TOPO_TRI_STRIP_ADJ: send_prim(INDEX_BITS'(1));
        TOPO_QUADS: send_prim('0);
        TOPO_QUAD_STRIP: begin
          send_prim('0);
          send_prim(INDEX_BITS'(1));
          send_prim(INDEX_BITS'(2));
        end
        default: ;
      endcase
    end

    // Full-width vertex counts and indices.
    configure(TOPO_POINTS, INDEX_MAX);
    send_prim(INDEX_MAX - INDEX_BITS'(1));
    send_prim(INDEX_MAX);
    configure(TOPO_TRI_STRIP_ADJ, INDEX_MAX);
    send_prim(prim_total - INDEX_BITS'(1));

    for (int ph = 0; ph < 10; ph++) begin
      no_idle = (ph % 4 == 2);
      configure(TOPO_BITS'($urandom_range(0, 15)), pick_verts());
      for (int i = 0; i < 20; i++) send_prim(pick_prim());
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    wait_drained();
    repeat (10) @(negedge clk);

    $display("Sent %0d primitive requests across %0d topology and vertex count settings.",
             prims_sent, settings_used);
    $display("Checked %0d corner beats, %0d still outstanding.", beats_seen, pending);
    if (mismatches == 0 && pending == 0)
      $display("primitive_topology_index_remap: match");
    else
      $display("primitive_topology_index_remap: mismatch");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ptir_pkg.sv
rtl/ptir_front.sv
rtl/ptir_queue.sv
rtl/ptir_back.sv
rtl/primitive_topology_index_remap.sv
bench/ptir_corner_checker.sv
bench/primitive_topology_index_remap_tb.sv
